>>> rtl/ima_pkg.sv
`timescale 1ns / 1ps

package ima_pkg;

  // Array sizes
  localparam int SPINS       = 128;
  localparam int WEIGHT_BITS = 16;
  localparam int IDX_W       = $clog2(SPINS);
  localparam int CADDR_W     = $clog2(SPINS * SPINS);

  // Fixed field widths of the channels
  localparam int REQ_W      = 2;
  localparam int INDEX_W    = 7;
  localparam int WFIELD_W   = 16;
  localparam int RAND_W     = 16;
  localparam int DELTA_W    = 32;
  localparam int ENERGY_W   = 40;
  localparam int BETA_W     = 32;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;

  // Register indexes and reset values
  localparam logic [CFG_ADDR_W-1:0] CFG_BETA_START = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BETA_STEP  = 8'd1;
  localparam logic [15:0]           BETA_STEP_RESET = 16'd655;

  // ln(2) in Q0.16 and the rounding half for the log scale
  localparam logic [31:0] LN2_Q16   = 32'd45426;
  localparam logic [47:0] HALF_Q16  = 48'd32768;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET_SPIN = 2'd0,
    REQ_LOAD     = 2'd1,
    REQ_TRY      = 2'd2,
    REQ_ADVANCE  = 2'd3
  } req_e;

  // Flat address of coupling row/col
  function automatic logic [CADDR_W-1:0] coup_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
    coup_addr = CADDR_W'(row) * CADDR_W'(SPINS) + CADDR_W'(col);
  endfunction

endpackage

>>> rtl/ima_req_if.sv
`timescale 1ns / 1ps

interface ima_req_if;
  logic                               valid;
  logic                               ready;
  logic [ima_pkg::REQ_W-1:0]          req_type;
  logic [ima_pkg::INDEX_W-1:0]        spin_index;
  logic [ima_pkg::INDEX_W-1:0]        other_index;
  logic signed [ima_pkg::WFIELD_W-1:0] weight;
  logic                               spin_value;
  logic [ima_pkg::RAND_W-1:0]         random_fraction;

  modport source (output valid, req_type, spin_index, other_index, weight, spin_value,
                  random_fraction, input ready);
  modport sink (input valid, req_type, spin_index, other_index, weight, spin_value,
                random_fraction, output ready);
endinterface

>>> rtl/ima_rsp_if.sv
`timescale 1ns / 1ps

interface ima_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                accepted;
  logic                                new_spin;
  logic signed [ima_pkg::DELTA_W-1:0]  energy_delta;
  logic signed [ima_pkg::ENERGY_W-1:0] energy_now;
  logic signed [ima_pkg::ENERGY_W-1:0] energy_best;

  modport source (output valid, accepted, new_spin, energy_delta, energy_now, energy_best,
                  input ready);
  modport sink (input valid, accepted, new_spin, energy_delta, energy_now, energy_best,
                output ready);
endinterface

>>> rtl/ima_cfg_if.sv
`timescale 1ns / 1ps

interface ima_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ima_pkg::CFG_ADDR_W-1:0]  index;
  logic [ima_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ima_ram.sv
`timescale 1ns / 1ps

module ima_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/ising_metropolis_annealer_top.sv
`timescale 1ns / 1ps

// Dense Ising annealer with Metropolis acceptance.
// req_i takes one request word (set spin, load coupling, try flip, advance
// temperature); rsp_o returns exactly one result word per request. cfg_i
// writes beta_start (index 0, also reloads the inverse temperature) and
// beta_step (index 1); it is always ready. The user must write it only
// while idle; the block itself does not enforce this. A rejected flip runs
// 16 squaring steps of the -ln table on the shared multiplier plus scale
// and compare; an accepted flip runs the table only when the delta is not
// negative and r is nonzero, and then walks one coupling row through the
// coupling, spin and delta memories at one entry a cycle. One request is in
// work at a time; req_i.ready is high only while idle, so the next request
// is taken at the earliest in the cycle after the previous result is
// registered.
// After reset a clearing pass zeroes the coupling, spin and delta memories;
// no request is taken meanwhile.
// A result waits in the output register while rsp_o.ready is low; the next
// request may be taken then, and its result holds until the register frees.
module ising_metropolis_annealer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  ima_req_if.sink           req_i,
  ima_rsp_if.source         rsp_o,
  ima_cfg_if.sink           cfg_i
);

  localparam int IW = ima_pkg::IDX_W;
  localparam int CW = ima_pkg::CADDR_W;
  localparam int WB = ima_pkg::WEIGHT_BITS;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_GOTA, ST_LD1, ST_LD2, ST_LNSQ, ST_LNSC, ST_CMP,
    ST_WSTART, ST_WALK, ST_WTAIL, ST_WFIN, ST_DONE
  } state_e;

  state_e state_q;

  // Request fields
  ima_pkg::req_e   req_q;
  logic [IW-1:0]   a_q, b_q;
  logic            a_ok_q, b_ok_q;
  logic [WB-1:0]   w_q;
  logic            sval_q;
  logic [15:0]     r_q;

  // Working registers
  logic            s_a_q, snew_q, take_q, res_spin_q;
  logic [31:0]     d_a_q, dbn_q;
  logic [16:0]     x_q;
  logic [3:0]      k_q, it_q;
  logic [15:0]     frac_q;
  logic [31:0]     lnv_q;
  logic [CW-1:0]   clr_q;
  logic [IW-1:0]   rj_q, wj_q;
  logic            wv_q;

  // Architectural state
  logic [15:0]     beta_step_q;
  logic [31:0]     beta_q;
  logic [39:0]     energy_q, best_q;

  // Output register
  logic            rv_q, racc_q, rspin_q;
  logic [31:0]     rdelta_q;
  logic [39:0]     rnow_q, rbest_q;

  // Memory ports
  logic            spin_we, spin_wdata, spin_rdata;
  logic [IW-1:0]   spin_waddr, spin_raddr;
  logic            delta_we;
  logic [IW-1:0]   delta_waddr, delta_raddr;
  logic [31:0]     delta_wdata, delta_rdata;
  logic            coup_we;
  logic [CW-1:0]   coup_waddr, coup_raddr;
  logic [WB-1:0]   coup_wdata, coup_rdata;

  // Shared multiplier
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;

  // Combinational helpers
  logic            in_acc, out_free;
  logic [31:0]     d_a_w;
  logic [39:0]     p40;
  logic [31:0]     p2;
  logic [31:0]     jx, tw;
  logic [17:0]     xsq;
  logic [3:0]      k_w;
  logic [16:0]     x0_w;
  logic [20:0]     l2_w;
  logic [47:0]     lsum;
  logic [32:0]     bsum;
  logic [31:0]     wext;

  assign in_acc      = req_i.valid && req_i.ready;
  assign out_free    = !rv_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid        = rv_q;
  assign rsp_o.accepted     = racc_q;
  assign rsp_o.new_spin     = rspin_q;
  assign rsp_o.energy_delta = rdelta_q;
  assign rsp_o.energy_now   = rnow_q;
  assign rsp_o.energy_best  = rbest_q;

  // Memories
  ima_ram #(.WIDTH(1), .DEPTH(ima_pkg::SPINS)) u_spin_ram (
    .clk_i(clk_i), .we_i(spin_we), .waddr_i(spin_waddr), .wdata_i(spin_wdata),
    .raddr_i(spin_raddr), .rdata_o(spin_rdata)
  );

  ima_ram #(.WIDTH(32), .DEPTH(ima_pkg::SPINS)) u_delta_ram (
    .clk_i(clk_i), .we_i(delta_we), .waddr_i(delta_waddr), .wdata_i(delta_wdata),
    .raddr_i(delta_raddr), .rdata_o(delta_rdata)
  );

  ima_ram #(.WIDTH(WB), .DEPTH(ima_pkg::SPINS * ima_pkg::SPINS)) u_coup_ram (
    .clk_i(clk_i), .we_i(coup_we), .waddr_i(coup_waddr), .wdata_i(coup_wdata),
    .raddr_i(coup_raddr), .rdata_o(coup_rdata)
  );

  // Datapath helpers
  always_comb begin
    d_a_w = a_ok_q ? delta_rdata : 32'd0;
    // Pair product of a load: +w when spins agree, -w otherwise
    p40   = 40'(signed'(w_q));
    if (s_a_q != spin_rdata) begin
      p40 = -p40;
    end
    p2    = 32'(p40) << 1;
    // Walk term 4*snew*s_j*J
    jx    = 32'(signed'(coup_rdata)) << 2;
    tw    = (snew_q == spin_rdata) ? jx : -jx;
    // Top set bit of r and normalized mantissa
    k_w   = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (r_q[i]) begin
        k_w = 4'(i);
      end
    end
    x0_w  = 17'({16'd0, r_q} << (5'd16 - {1'b0, k_w}));
    l2_w  = {5'd16 - {1'b0, k_q}, 16'd0} - {5'd0, frac_q};
    wext  = 32'(req_i.weight);
    bsum  = {1'b0, beta_q} + {17'd0, beta_step_q};
  end

  // Multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_q)
      ST_LNSQ: begin
        mul_a = {15'd0, x_q};
        mul_b = {15'd0, x_q};
      end
      ST_LNSC: begin
        mul_a = {11'd0, l2_w};
        mul_b = ima_pkg::LN2_Q16;
      end
      ST_CMP: begin
        mul_a = d_a_q;
        mul_b = beta_q;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    xsq   = mul_p[33:16];
    lsum  = mul_p[47:0] + ima_pkg::HALF_Q16;
  end

  // Memory addressing and writes
  always_comb begin
    spin_we     = 1'b0;
    spin_waddr  = a_q;
    spin_wdata  = 1'b0;
    delta_we    = 1'b0;
    delta_waddr = a_q;
    delta_wdata = 32'd0;
    coup_we     = 1'b0;
    coup_waddr  = ima_pkg::coup_addr(a_q, b_q);
    coup_wdata  = w_q;
    spin_raddr  = a_q;
    delta_raddr = a_q;
    coup_raddr  = ima_pkg::coup_addr(a_q, rj_q);
    case (state_q)
      ST_CLEAR: begin
        spin_we     = 1'b1;
        spin_waddr  = clr_q[IW-1:0];
        delta_we    = 1'b1;
        delta_waddr = clr_q[IW-1:0];
        coup_we     = 1'b1;
        coup_waddr  = clr_q;
        coup_wdata  = '0;
      end
      ST_IDLE: begin
        spin_raddr  = IW'(req_i.spin_index);
        delta_raddr = IW'(req_i.spin_index);
      end
      ST_GOTA: begin
        spin_raddr  = b_q;
        delta_raddr = b_q;
        spin_we     = (req_q == ima_pkg::REQ_SET_SPIN) && a_ok_q;
        spin_wdata  = sval_q;
      end
      ST_LD1: begin
        delta_we    = 1'b1;
        delta_wdata = d_a_q - p2;
        coup_we     = 1'b1;
      end
      ST_LD2: begin
        delta_we    = 1'b1;
        delta_waddr = b_q;
        delta_wdata = dbn_q;
        coup_we     = 1'b1;
        coup_waddr  = ima_pkg::coup_addr(b_q, a_q);
      end
      ST_WALK, ST_WTAIL: begin
        spin_raddr  = rj_q;
        delta_raddr = rj_q;
        delta_we    = wv_q;
        delta_waddr = wj_q;
        delta_wdata = delta_rdata - tw;
      end
      ST_WFIN: begin
        delta_we    = 1'b1;
        delta_wdata = -d_a_q;
        spin_we     = 1'b1;
        spin_wdata  = snew_q;
      end
      default: begin
        spin_we = 1'b0;
      end
    endcase
  end

  // Sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      beta_step_q  <= ima_pkg::BETA_STEP_RESET;
      beta_q       <= 32'd0;
      energy_q     <= 40'd0;
      best_q       <= 40'd0;
      rv_q         <= 1'b0;
      wv_q         <= 1'b0;
      req_q        <= ima_pkg::REQ_SET_SPIN;
    end else begin
      wv_q <= (state_q == ST_WALK);
      if (rv_q && rsp_o.ready && (state_q != ST_DONE)) begin
        rv_q <= 1'b0;
      end

      // Take register writes
      if (cfg_i.valid) begin
        if (cfg_i.index == ima_pkg::CFG_BETA_START) begin
          beta_q       <= {8'd0, cfg_i.data[23:0]};
        end else if (cfg_i.index == ima_pkg::CFG_BETA_STEP) begin
          beta_step_q <= cfg_i.data[15:0];
        end
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CW'(ima_pkg::SPINS * ima_pkg::SPINS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            req_q   <= ima_pkg::req_e'(req_i.req_type);
            a_q     <= IW'(req_i.spin_index);
            b_q     <= IW'(req_i.other_index);
            a_ok_q  <= 32'(req_i.spin_index) < ima_pkg::SPINS;
            b_ok_q  <= 32'(req_i.other_index) < ima_pkg::SPINS;
            w_q     <= wext[WB-1:0];
            sval_q  <= req_i.spin_value;
            r_q     <= req_i.random_fraction;
            take_q  <= 1'b0;
            state_q <= ST_GOTA;
          end
        end
        ST_GOTA: begin
          s_a_q      <= spin_rdata && a_ok_q;
          d_a_q      <= d_a_w;
          res_spin_q <= (req_q == ima_pkg::REQ_SET_SPIN) ? (sval_q && a_ok_q)
                                                          : (spin_rdata && a_ok_q);
          case (req_q)
            ima_pkg::REQ_LOAD: begin
              state_q <= (a_ok_q && b_ok_q && (a_q != b_q)) ? ST_LD1 : ST_DONE;
            end
            ima_pkg::REQ_TRY: begin
              if (a_ok_q && (d_a_w[31] || (r_q == 16'd0))) begin
                state_q <= ST_WSTART;
              end else if (a_ok_q) begin
                k_q     <= k_w;
                x_q     <= x0_w;
                it_q    <= 4'd0;
                frac_q  <= 16'd0;
                state_q <= ST_LNSQ;
              end else begin
                state_q <= ST_DONE;
              end
            end
            ima_pkg::REQ_ADVANCE: begin
              beta_q  <= bsum[32] ? 32'hFFFF_FFFF : bsum[31:0];
              state_q <= ST_DONE;
            end
            default: begin
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_LD1: begin
          dbn_q    <= delta_rdata - p2;
          energy_q <= energy_q + p40;
          state_q  <= ST_LD2;
        end
        ST_LD2: begin
          state_q <= ST_DONE;
        end
        // Square, renormalize and shift in one fraction bit per step
        ST_LNSQ: begin
          if (xsq[17]) begin
            x_q                  <= xsq[17:1];
            frac_q[4'd15 - it_q] <= 1'b1;
          end else begin
            x_q <= xsq[16:0];
          end
          it_q <= it_q + 1'b1;
          if (it_q == 4'd15) begin
            state_q <= ST_LNSC;
          end
        end
        ST_LNSC: begin
          lnv_q   <= lsum[47:16];
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          state_q <= (mul_p < {32'd0, lnv_q}) ? ST_WSTART : ST_DONE;
        end
        ST_WSTART: begin
          energy_q <= energy_q + 40'(signed'(d_a_q));
          snew_q   <= !s_a_q;
          rj_q     <= '0;
          state_q  <= ST_WALK;
        end
        // Issue row reads; write back the entry read in the previous cycle
        ST_WALK: begin
          wj_q <= rj_q;
          if (rj_q == IW'(ima_pkg::SPINS - 1)) begin
            state_q <= ST_WTAIL;
          end else begin
            rj_q <= rj_q + 1'b1;
          end
        end
        ST_WTAIL: begin
          state_q <= ST_WFIN;
        end
        ST_WFIN: begin
          take_q     <= 1'b1;
          res_spin_q <= snew_q;
          if (signed'(energy_q) < signed'(best_q)) begin
            best_q <= energy_q;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            rv_q     <= 1'b1;
            racc_q   <= take_q;
            rspin_q  <= res_spin_q;
            rdelta_q <= d_a_q;
            rnow_q   <= energy_q;
            rbest_q  <= best_q;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted flip leaves the best energy at or below the current one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.accepted |-> $signed(rsp_o.energy_best) <= $signed(rsp_o.energy_now))
    else $error("best energy above current energy after accepted flip");

  // The row walk only leaves through its tail cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |=> state_q == ST_WALK || state_q == ST_WTAIL)
    else $error("row walk left early");

  // Final delta and spin write follows the last walk write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WFIN |-> $past(state_q) == ST_WTAIL && !wv_q)
    else $error("flip finish out of order");

endmodule

>>> bench/tb_ifs.sv
`timescale 1ns / 1ps

// Bench-side copies are not needed: the block's own interfaces are reused.
// This file holds the shared bench types.
package tb_ima_pkg;
  import ima_pkg::*;

  typedef struct packed {
    req_e                        kind;
    logic [INDEX_W-1:0]          a;
    logic [INDEX_W-1:0]          b;
    logic signed [WFIELD_W-1:0]  w;
    logic                        sval;
    logic [RAND_W-1:0]           r;
  } ising_req_t;

  typedef struct packed {
    logic                        accepted;
    logic                        new_spin;
    logic signed [DELTA_W-1:0]   delta;
    logic signed [ENERGY_W-1:0]  e_now;
    logic signed [ENERGY_W-1:0]  e_best;
  } ising_rsp_t;

  // Predicts the annealer results and holds the ones still to arrive
  class annealer_scoreboard;
    bit                          spin[SPINS];
    logic signed [WFIELD_W-1:0]  coup[SPINS][SPINS];
    logic [DELTA_W-1:0]          fdelta[SPINS];
    logic [BETA_W-1:0]           beta;
    logic [15:0]                 beta_step;
    logic [ENERGY_W-1:0]         e_now;
    logic [ENERGY_W-1:0]         e_best;
    ising_rsp_t                  pending[$];
    int                          errors;
    int                          checked;
    int                          flips;

    function new();
      for (int i = 0; i < SPINS; i++) begin
        spin[i] = 0;
        fdelta[i] = '0;
        for (int j = 0; j < SPINS; j++) coup[i][j] = '0;
      end
      beta = '0;
      beta_step = BETA_STEP_RESET;
      e_now = '0;
      e_best = '0;
      errors = 0;
      checked = 0;
      flips = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == CFG_BETA_START) beta = {8'd0, d[23:0]};
      else if (idx == CFG_BETA_STEP) beta_step = d[15:0];
    endfunction

    // -ln(r/2^16) in Q16.16 through a bitwise log2
    function logic [31:0] neg_log(logic [15:0] r);
      int k;
      logic [63:0] x;
      logic [15:0] frac;
      logic [63:0] l2;
      k = 15;
      while (k > 0 && !r[k]) k--;
      x = 64'(r) << (16 - k);
      frac = '0;
      for (int i = 1; i <= 16; i++) begin
        x = (x * x) >> 16;
        if (x >= 64'd131072) begin
          x = x >> 1;
          frac[16-i] = 1'b1;
        end
      end
      l2 = 64'(16 - k) * 64'd65536 - 64'(frac);
      return 32'((l2 * 64'd45426 + 64'd32768) >> 16);
    endfunction

    function void note_request(ising_req_t q);
      ising_rsp_t          res;
      logic signed [63:0]  p, d, t;
      logic [63:0]         nb;
      bit                  take;
      int                  sn;
      res = '0;
      res.delta = fdelta[q.a];
      case (q.kind)
        REQ_SET_SPIN: spin[q.a] = q.sval;
        REQ_LOAD: begin
          if (q.a != q.b) begin
            p = 64'(q.w);
            if (spin[q.a] != spin[q.b]) p = -p;
            coup[q.a][q.b] = q.w;
            coup[q.b][q.a] = q.w;
            fdelta[q.a] = fdelta[q.a] - 32'(2 * p);
            fdelta[q.b] = fdelta[q.b] - 32'(2 * p);
            e_now = e_now + 40'(p);
          end
        end
        REQ_TRY: begin
          d = 64'($signed(fdelta[q.a]));
          if (d < 0 || q.r == 0) take = 1;
          else take = (64'(d) * 64'(beta)) < 64'(neg_log(q.r));
          if (take) begin
            flips++;
            res.accepted = 1'b1;
            sn = spin[q.a] ? -1 : 1;
            e_now = e_now + 40'(d);
            for (int j = 0; j < SPINS; j++) begin
              t = 64'(4 * sn * (spin[j] ? 1 : -1)) * 64'(coup[q.a][j]);
              fdelta[j] = fdelta[j] - 32'(t);
            end
            fdelta[q.a] = -fdelta[q.a];
            spin[q.a] = (sn > 0);
            if ($signed(e_now) < $signed(e_best)) e_best = e_now;
          end
        end
        default: begin
          nb = 64'(beta) + 64'(beta_step);
          beta = (nb > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nb[31:0];
        end
      endcase
      res.new_spin = spin[q.a];
      res.e_now = e_now;
      res.e_best = e_best;
      pending.insert(pending.size(), res);
    endfunction

    function void check_result(ising_rsp_t got);
      ising_rsp_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.accepted !== exp_r.accepted) begin
        $display("%0t: accepted exp %0b got %0b", $time, exp_r.accepted, got.accepted);
        errors++;
      end
      if (got.new_spin !== exp_r.new_spin) begin
        $display("%0t: new_spin exp %0b got %0b", $time, exp_r.new_spin, got.new_spin);
        errors++;
      end
      if (got.delta !== exp_r.delta) begin
        $display("%0t: energy_delta exp %0d got %0d", $time, exp_r.delta, got.delta);
        errors++;
      end
      if (got.e_now !== exp_r.e_now) begin
        $display("%0t: energy_now exp %0d got %0d", $time, exp_r.e_now, got.e_now);
        errors++;
      end
      if (got.e_best !== exp_r.e_best) begin
        $display("%0t: energy_best exp %0d got %0d", $time, exp_r.e_best, got.e_best);
        errors++;
      end
    endfunction
  endclass
endpackage

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import ima_pkg::*;
  import tb_ima_pkg::*;

  logic clk_i;
  logic rst_ni;

  ima_req_if req_if ();
  ima_rsp_if rsp_if ();
  ima_cfg_if cfg_if ();

  ising_metropolis_annealer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source),
    .cfg_i  (cfg_if.sink)
  );

  annealer_scoreboard sb;
  int                 sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, sometimes long
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drive one word; valid stays high into the next word unless a gap follows
  task automatic send_req(ising_req_t q);
    int g;
    g = gap_len();
    @(negedge clk_i);
    if (g > 0) begin
      req_if.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.req_type        <= q.kind;
    req_if.spin_index      <= q.a;
    req_if.other_index     <= q.b;
    req_if.weight          <= q.w;
    req_if.spin_value      <= q.sval;
    req_if.random_fraction <= q.r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(q);
    sent++;
  endtask

  // Drop the request valid after the last word of a burst
  task automatic hold_off();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
  endtask

  // Wait for every result, then let the block settle before a register write
  task automatic drain();
    hold_off();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (SPINS + 40) @(negedge clk_i);
  endtask

  function automatic ising_req_t mk(req_e k, int a, int b, int w, bit s, int r);
    ising_req_t q;
    q.kind = k;
    q.a = a[INDEX_W-1:0];
    q.b = b[INDEX_W-1:0];
    q.w = w[WFIELD_W-1:0];
    q.sval = s;
    q.r = r[RAND_W-1:0];
    return q;
  endfunction

  // Random request; small working set so couplings interact with flips
  function automatic ising_req_t rand_req(int nsp);
    int   roll;
    req_e k;
    roll = $urandom_range(0, 99);
    if (roll < 10) k = REQ_SET_SPIN;
    else if (roll < 40) k = REQ_LOAD;
    else if (roll < 93) k = REQ_TRY;
    else k = REQ_ADVANCE;
    if ($urandom_range(0, 9) == 0)
      return mk(k, $urandom_range(0, 127), $urandom_range(0, 127), $urandom,
                1'($urandom), $urandom);
    return mk(k, $urandom_range(0, nsp - 1), $urandom_range(0, nsp - 1),
              ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 400)) - 200,
              1'($urandom), ($urandom_range(0, 9) == 0) ? 0 : $urandom);
  endfunction

  // Result side: random stalls, check at the rising edge
  initial begin
    int g;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if (g > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result({rsp_if.accepted, rsp_if.new_spin, rsp_if.energy_delta,
                         rsp_if.energy_now, rsp_if.energy_best});
    end
  end

  initial begin
    #200ms;
    $display("Timeout at %0t", $time);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [31:0] betas[4];
    logic [15:0] steps[4];
    sb = new();
    sent = 0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_SET_SPIN;
    req_if.spin_index = '0;
    req_if.other_index = '0;
    req_if.weight = '0;
    req_if.spin_value = 1'b0;
    req_if.random_fraction = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every request, self coupling, r zero
    send_req(mk(REQ_TRY, 0, 0, 0, 0, 0));
    send_req(mk(REQ_TRY, 127, 0, 0, 0, 16'hFFFF));
    send_req(mk(REQ_SET_SPIN, 127, 0, 0, 1, 0));
    send_req(mk(REQ_LOAD, 0, 127, -32768, 1, 0));
    send_req(mk(REQ_LOAD, 1, 126, 32767, 0, 16'hFFFF));
    send_req(mk(REQ_LOAD, 5, 5, 1234, 0, 0));
    send_req(mk(REQ_LOAD, 0, 127, 100, 0, 0));
    send_req(mk(REQ_TRY, 0, 0, 0, 0, 1));
    send_req(mk(REQ_TRY, 127, 0, 0, 0, 16'h8000));
    send_req(mk(REQ_TRY, 1, 0, 0, 0, 0));
    send_req(mk(REQ_ADVANCE, 0, 0, 0, 0, 0));
    send_req(mk(REQ_TRY, 126, 0, 0, 1, 16'h7FFF));
    send_req(mk(REQ_SET_SPIN, 0, 127, 0, 0, 0));
    send_req(mk(REQ_TRY, 0, 0, 0, 0, 1));
    drain();

    // Phases over several register settings, extremes included
    betas = '{32'h00FF_FFFF, 32'h0, 32'h0000_0800, 32'h0001_0000};
    steps = '{16'hFFFF, 16'h0, 16'd300, 16'd20};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_BETA_START, betas[ph] | (ph == 0 ? 32'hFF00_0000 : 32'h0));
      write_reg(CFG_BETA_STEP, steps[ph] | (ph == 0 ? 32'hFFFF_0000 : 32'h0));
      for (int i = 0; i < 385; i++) begin
        send_req(rand_req(ph == 3 ? 128 : 12));
        // Let the block empty out once per phase
        if (i == 200) begin
          hold_off();
          while (sb.pending.size() != 0) @(negedge clk_i);
        end
      end
      if (ph == 0)
        for (int i = 0; i < 300; i++) send_req(mk(REQ_ADVANCE, 0, 0, 0, 0, 0));
      drain();
    end

    $display("Sent %0d requests, checked %0d results, %0d accepted flips",
             sent, sb.checked, sb.flips);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
